@@ rtl/ipv6tp_pkg.sv @@
`default_nettype none

package ipv6tp_pkg;

  localparam int unsigned NUM_GROUPS = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned ADDR_W     = NUM_GROUPS * GROUP_W;

  localparam logic [5:0] MAX_CHARS  = 6'd39;
  localparam logic [2:0] MAX_DIGITS = 3'd4;
  localparam logic [3:0] GROUPS_MAX = 4'd8;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // colons seen in a row just before the current character
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_ONE  = 2'd1,
    RUN_TWO  = 2'd2
  } colon_run_t;

  // group 0 sits at index 0, which is the most significant end
  typedef logic [0:NUM_GROUPS-1][GROUP_W-1:0] group_arr_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff  = c - 8'h30;
      d.ok  = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff  = c - 8'h57;
      d.ok  = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff  = c - 8'h37;
      d.ok  = 1'b1;
    end
    d.value = diff[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipv6_text_address_parser.sv @@
// stages: a character is registered in the input stage on acceptance and stepped from there;
//   the result of a last character is then registered in the result register
// throughput: one character per cycle, held back only while a finished result is not taken
// groups before a double colon go into a head register by index, groups after it shift
//   into a tail register, so the tail lands right-aligned and the address is head | tail
// reset (rst, synchronous, active high) empties both stages and clears all parse state
`default_nettype none

module ipv6_text_address_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             valid_res,
  output logic [63:0]      addr_high,
  output logic [63:0]      addr_low
);

  import ipv6tp_pkg::*;

  // input stage: one request held for the step logic
  logic       in_q_valid;
  logic [7:0] ch_q;
  logic       last_q;

  // parse state
  group_arr_t  head;
  group_arr_t  tail;
  logic [15:0] current_group;
  logic [2:0]  digit_count;
  logic [3:0]  group_count;
  logic [3:0]  gap_position;
  logic        gap_seen;
  colon_run_t  colon_run;
  logic [5:0]  char_count;
  logic        leading_colon;
  logic        error_flag;

  // next values
  group_arr_t  head_next;
  group_arr_t  tail_next;
  logic [15:0] current_group_next;
  logic [2:0]  digit_count_next;
  logic [3:0]  group_count_next;
  logic [3:0]  gap_position_next;
  logic        gap_seen_next;
  colon_run_t  colon_run_next;
  logic [5:0]  char_count_next;
  logic        leading_colon_next;
  logic        error_flag_next;

  logic              finish;
  logic              res_ok;
  logic [ADDR_W-1:0] full_addr;
  hex_digit_t        hd;

  logic out_free;
  logic advance;

  // the output register is free when empty or being emptied this cycle
  assign out_free = !out_valid || out_ready;
  // a character without the last mark never needs the output register
  assign advance  = in_q_valid && (!last_q || out_free);
  assign in_ready = !in_q_valid || advance;

  assign hd = hex_decode(ch_q);

  // one character step, then the end-of-text checks when last is set
  always_comb begin
    head_next          = head;
    tail_next          = tail;
    current_group_next = current_group;
    digit_count_next   = digit_count;
    group_count_next   = group_count;
    gap_position_next  = gap_position;
    gap_seen_next      = gap_seen;
    colon_run_next     = colon_run;
    char_count_next    = char_count;
    leading_colon_next = leading_colon;
    error_flag_next    = error_flag;
    finish             = 1'b0;
    res_ok             = 1'b0;

    if (!error_flag) begin
      if (char_count >= MAX_CHARS) begin
        error_flag_next = 1'b1;
      end else begin
        char_count_next = char_count + 6'd1;
        if (ch_q == CHAR_COLON) begin
          case (colon_run)
            RUN_NONE: begin
              if (digit_count != 3'd0) begin
                finish = 1'b1;
              end else begin
                leading_colon_next = 1'b1;
              end
              colon_run_next = RUN_ONE;
            end
            RUN_ONE: begin
              if (gap_seen) begin
                error_flag_next = 1'b1;
              end else begin
                gap_seen_next     = 1'b1;
                gap_position_next = group_count;
                colon_run_next    = RUN_TWO;
              end
            end
            default: begin
              // third colon in a row
              error_flag_next = 1'b1;
            end
          endcase
        end else if (!hd.ok) begin
          error_flag_next = 1'b1;
        end else if (leading_colon && !gap_seen) begin
          // lone leading colon
          error_flag_next = 1'b1;
        end else if (digit_count >= MAX_DIGITS) begin
          error_flag_next = 1'b1;
        end else begin
          current_group_next = {current_group[11:0], hd.value};
          digit_count_next   = digit_count + 3'd1;
          colon_run_next     = RUN_NONE;
        end
      end
    end

    if (last_q) begin
      // lone trailing colon
      if (!error_flag_next && colon_run_next == RUN_ONE) begin
        error_flag_next = 1'b1;
      end
      if (!error_flag_next && digit_count_next != 3'd0) begin
        finish = 1'b1;
      end
    end

    // close the current group: before the gap by index, after it by shifting
    if (finish) begin
      if (group_count_next >= GROUPS_MAX) begin
        error_flag_next = 1'b1;
      end else begin
        if (gap_seen_next) begin
          tail_next = {tail_next[1:NUM_GROUPS-1], current_group_next};
        end else begin
          head_next[group_count_next[2:0]] = current_group_next;
        end
        group_count_next   = group_count_next + 4'd1;
        current_group_next = '0;
        digit_count_next   = '0;
      end
    end

    if (!error_flag_next) begin
      if (gap_seen_next) begin
        res_ok = (group_count_next <= GROUPS_MAX) && (gap_position_next <= group_count_next);
      end else begin
        res_ok = (group_count_next == GROUPS_MAX);
      end
    end
  end

  assign full_addr = head_next | tail_next;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      ch_q   <= ch;
      last_q <= last;
    end
  end

  // parse state, back to its reset value after every last character
  always_ff @(posedge clk) begin
    if (rst || (advance && last_q)) begin
      head          <= '0;
      tail          <= '0;
      current_group <= '0;
      digit_count   <= '0;
      group_count   <= '0;
      gap_position  <= '0;
      gap_seen      <= 1'b0;
      colon_run     <= RUN_NONE;
      char_count    <= '0;
      leading_colon <= 1'b0;
      error_flag    <= 1'b0;
    end else if (advance) begin
      head          <= head_next;
      tail          <= tail_next;
      current_group <= current_group_next;
      digit_count   <= digit_count_next;
      group_count   <= group_count_next;
      gap_position  <= gap_position_next;
      gap_seen      <= gap_seen_next;
      colon_run     <= colon_run_next;
      char_count    <= char_count_next;
      leading_colon <= leading_colon_next;
      error_flag    <= error_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && last_q) begin
      valid_res <= res_ok;
      addr_high <= res_ok ? full_addr[ADDR_W-1:ADDR_W/2] : 64'd0;
      addr_low  <= res_ok ? full_addr[ADDR_W/2-1:0] : 64'd0;
    end
  end

  // a rejected text never carries an address
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> addr_high == 64'd0 && addr_low == 64'd0)
    else $error("rejected result carries a non-zero address");

  // a stepped last character always produces a result
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    advance && last_q |=> out_valid)
    else $error("last character stepped without a result");

  // input is only held off while a last character waits in the input stage behind a full result register
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_q_valid && last_q && out_valid)
    else $error("input stalled without a pending last character");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= MAX_DIGITS)
    else $error("digit count beyond four");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    group_count <= GROUPS_MAX && gap_position <= group_count)
    else $error("group count or gap position out of range");

endmodule

`default_nettype wire

@@ sim/ipv6_text_address_parser_tb.sv @@
`timescale 1ns / 100ps

module ipv6_text_address_parser_tb;
  import ipv6tp_pkg::*;

  // longest run of cycles with no request moving on either side
  localparam int unsigned QUIET_LIMIT = 3000;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 400;
  // characters per random phase, ignored characters not counted
  localparam int unsigned PHASE_CHARS = 335;

  typedef struct {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  // tracks the parse the way the block should, and holds the addresses still owed
  class addr_scoreboard;
    logic [15:0]  grp [NUM_GROUPS];
    logic [15:0]  cur;
    int unsigned  ndig;
    int unsigned  ngrp;
    int unsigned  gap_at;
    int unsigned  nchar;
    bit           has_gap;
    bit           lead_colon;
    bit           bad;
    colon_run_t   run;
    addr_result_t owed_q [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (grp[i]) grp[i] = '0;
      cur        = '0;
      ndig       = 0;
      ngrp       = 0;
      gap_at     = 0;
      nchar      = 0;
      has_gap    = 0;
      lead_colon = 0;
      bad        = 0;
      run        = RUN_NONE;
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void close_group();
      if (ngrp >= NUM_GROUPS) begin
        bad = 1;
        return;
      end
      grp[ngrp] = cur;
      ngrp++;
      cur  = '0;
      ndig = 0;
    endfunction

    // returns 0 when the character is ignored after an earlier rejection
    function bit take_char(logic [7:0] c);
      int v;
      if (bad) return 0;
      if (nchar >= MAX_CHARS) begin
        bad = 1;
        return 1;
      end
      nchar++;
      if (c == CHAR_COLON) begin
        case (run)
          RUN_NONE: begin
            if (ndig > 0) close_group();
            else lead_colon = 1;
            run = RUN_ONE;
          end
          RUN_ONE: begin
            if (has_gap) begin
              bad = 1;
              return 1;
            end
            has_gap = 1;
            gap_at  = ngrp;
            run     = RUN_TWO;
          end
          default: bad = 1;
        endcase
        return 1;
      end
      v = hex_of(c);
      if (v < 0) begin
        bad = 1;
        return 1;
      end
      if (lead_colon && !has_gap) begin
        bad = 1;
        return 1;
      end
      if (ndig >= MAX_DIGITS) begin
        bad = 1;
        return 1;
      end
      cur  = {cur[11:0], 4'(v)};
      ndig++;
      run  = RUN_NONE;
      return 1;
    endfunction

    function void finish_text();
      addr_result_t r;
      logic [15:0]  full [NUM_GROUPS];
      int unsigned  tail;
      int unsigned  base;
      if (!bad && run == RUN_ONE) bad = 1;
      if (!bad && ndig > 0) close_group();
      r.ok = !bad;
      if (r.ok) r.ok = has_gap ? (ngrp <= NUM_GROUPS && gap_at <= ngrp) : (ngrp == NUM_GROUPS);
      r.hi = '0;
      r.lo = '0;
      if (r.ok) begin
        foreach (full[i]) full[i] = '0;
        for (int i = 0; i < gap_at; i++) full[i] = grp[i];
        tail = ngrp - gap_at;
        base = NUM_GROUPS - tail;
        for (int i = 0; i < tail; i++)
          full[(base + i) % NUM_GROUPS] = grp[(gap_at + i) % NUM_GROUPS];
        r.hi = {full[0], full[1], full[2], full[3]};
        r.lo = {full[4], full[5], full[6], full[7]};
      end
      owed_q.insert(owed_q.size(), r);
      clear();
    endfunction

    function bit note_char(logic [7:0] c, logic l);
      bit taken;
      taken = take_char(c);
      if (l) finish_text();
      return taken;
    endfunction

    function void check_result(logic ok, logic [63:0] hi, logic [63:0] lo);
      addr_result_t w;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ok=%0b hi=%h lo=%h", ok, hi, lo);
        return;
      end
      w = owed_q.pop_front();
      if (ok !== w.ok || hi !== w.hi || lo !== w.lo) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected ok=%0b hi=%h lo=%h, got ok=%0b hi=%h lo=%h",
                   w.ok, w.hi, w.lo, ok, hi, lo);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  ch        = '0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        valid_res;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  addr_scoreboard sb = new();

  // idle chances in percent, changed between phases
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // a toggle here starts a long receiver hold-off counted on the receiver side
  logic        stall_kick = 1'b0;
  logic        stall_seen = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned quiet      = 0;

  // characters of the address being built
  logic [7:0] text_q [$];

  ipv6_text_address_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: check each result taken, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(valid_res, addr_high, addr_low);
    if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles where no request moves
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // appends one character to the address being built
  task automatic put_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  // one character request; valid stays up after acceptance until the caller
  // offers the next character or lowers it
  task automatic send_char(input logic [7:0] c, input logic l, output bit taken);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    taken = sb.note_char(c, l);
  endtask

  task automatic send_text(output int unsigned taken_n);
    bit taken;
    taken_n = 0;
    foreach (text_q[i]) begin
      send_char(text_q[i], i == text_q.size() - 1, taken);
      taken_n += taken;
    end
    text_q.delete();
  endtask

  task automatic send_str(input string s);
    int unsigned n;
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    send_text(n);
  endtask

  // sender pauses here until every owed address has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  task automatic add_group();
    repeat ($urandom_range(1, 4)) put_char(rand_hex());
  endtask

  // well formed text: either eight plain groups or a head, a double colon and a tail
  task automatic make_address();
    int unsigned ng;
    int unsigned nh;
    if ($urandom_range(1)) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
    end else begin
      ng = $urandom_range(NUM_GROUPS);
      nh = $urandom_range(ng);
      for (int i = 0; i < nh; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
      put_char(CHAR_COLON);
      put_char(CHAR_COLON);
      for (int i = 0; i < ng - nh; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
    end
  endtask

  // break a well formed text in one of several ways
  task automatic corrupt();
    int unsigned at;
    at = $urandom_range(text_q.size() - 1);
    case ($urandom_range(7))
      0: text_q[at] = 8'($urandom_range(255));
      1: text_q.insert(at, CHAR_COLON);
      2: text_q.push_front(CHAR_COLON);
      3: put_char(CHAR_COLON);
      4: text_q.insert(at, rand_hex());
      5: begin
        put_char(CHAR_COLON);
        add_group();
      end
      6: text_q.delete(at);
      default: begin
        text_q.insert(at, CHAR_COLON);
        text_q.insert(at, CHAR_COLON);
      end
    endcase
    if (text_q.size() == 0) put_char(rand_hex());
  endtask

  // arbitrary bytes, mostly drawn from the address alphabet
  task automatic make_noise();
    repeat ($urandom_range(1, 44)) begin
      if ($urandom_range(99) < 70)
        put_char($urandom_range(5) == 0 ? CHAR_COLON : rand_hex());
      else
        put_char(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned got;
    int unsigned n;
    int unsigned pick;
    got = 0;
    while (got < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        make_address();
      end else if (pick < 88) begin
        make_address();
        repeat ($urandom_range(1, 2)) corrupt();
      end else begin
        make_noise();
      end
      send_text(n);
      got += n;
    end
  endtask

  task automatic directed();
    string cases [$];
    int unsigned n;
    cases = '{
      "0:0:0:0:0:0:0:0",
      "FFFF:ffff:FFFF:ffff:FFFF:ffff:FFFF:ffff",
      "::",
      "::1",
      "1::",
      "1:2:3::4:5:6:7:8",
      "1:2:3:4:5:6:7:8::",
      "aB:Cd::eF09",
      "1234:5678:9abc:def0:1234:5678:9abc:def0",
      // forty characters, the last one is one too many
      "0000:0000:0000:0000:0000:0000:0000:0000:",
      "1:2:3:4:5:6:7:g",
      "12345::",
      "1:2:3:4:5:6:7:8:9",
      "1::2::3",
      "1:::2",
      ":1:2:3:4:5:6:7",
      "1:2:3:4:5:6:7:",
      ":",
      "1:2:3:4:5:6:7",
      "::ffff:0"
    };
    foreach (cases[i]) send_str(cases[i]);
    // extremes of the character field as one-character texts
    put_char(8'h00);
    send_text(n);
    put_char(8'hFF);
    send_text(n);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: light sender idling, heavy receiver idling
    tx_idle_pct = 11;
    rx_idle_pct = 46;
    directed();
    drain();
    // long receiver hold-off while characters keep coming
    stall_kick <= ~stall_kick;
    random_phase(PHASE_CHARS);
    drain();

    // phase two: roles swapped
    tx_idle_pct = 46;
    rx_idle_pct = 11;
    random_phase(PHASE_CHARS);
    drain();

    // phase three: full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(PHASE_CHARS);
    drain();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
